// File: design/isp_pkg.sv
// Shared types and constants of the IMU serial packet parser.
`default_nettype none

package isp_pkg;

    // Frame layout
    localparam logic [7:0] FRAME_HEADER   = 8'h55;
    localparam logic [3:0] POS_FIRST_DATA = 4'd2;
    localparam logic [3:0] POS_CHECKSUM   = 4'd10;
    localparam int unsigned DATA_BYTES    = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACCEL_TYPE = 2'd0;
    localparam logic [1:0] CFG_GYRO_TYPE  = 2'd1;
    localparam logic [1:0] CFG_ANGLE_TYPE = 2'd2;

    // Reset values of the type code registers
    localparam logic [7:0] ACCEL_TYPE_RESET = 8'd81;
    localparam logic [7:0] GYRO_TYPE_RESET  = 8'd82;
    localparam logic [7:0] ANGLE_TYPE_RESET = 8'd83;

    // Result kinds
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    // Scale factors, applied as multiply then arithmetic shift right (floor)
    localparam logic signed [17:0] ACCEL_COEF  = 18'sd80282;
    localparam logic signed [17:0] GYRO_COEF   = 18'sd125;
    localparam logic signed [17:0] ANGLE_COEF  = 18'sd45;
    localparam logic signed [18:0] TEMP_COEF   = 19'sd167772;
    localparam int unsigned        ACCEL_SHIFT = 16;
    localparam int unsigned        GYRO_SHIFT  = 3;
    localparam int unsigned        ANGLE_SHIFT = 5;
    localparam int unsigned        TEMP_SHIFT  = 16;

    // A checked frame handed from the framer to the scaler
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [15:0] raw_t;
    } frame_t;

endpackage

`default_nettype wire

// File: design/isp_framer.sv
// Byte-wise frame assembly, checksum check and type decode.
`default_nettype none

module isp_framer
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    byte_in,
    output logic               frame_valid,
    output isp_pkg::frame_t    frame,
    input  wire logic          frame_take
);
    import isp_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [7:0] accel_code_reg;
    logic [7:0] gyro_code_reg;
    logic [7:0] angle_code_reg;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] data_reg [DATA_BYTES];

    logic       frame_valid_reg, frame_valid_next;
    frame_t     frame_reg;

    logic       accept;
    logic [3:0] pos_eff;
    logic [3:0] pos_off;
    logic       data_we;
    logic [2:0] data_idx;
    logic       frame_done;
    logic       type_known;
    logic [1:0] kind;

    assign accept   = in_valid && !in_stall;
    // Every byte stalls while the frame register holds a frame that is not being taken.
    assign in_stall = frame_valid_reg && !frame_take;

    always_comb
    begin
        if (type_reg == accel_code_reg)
        begin
            kind       = KIND_ACCEL;
            type_known = 1'b1;
        end
        else if (type_reg == gyro_code_reg)
        begin
            kind       = KIND_GYRO;
            type_known = 1'b1;
        end
        else if (type_reg == angle_code_reg)
        begin
            kind       = KIND_ANGLE;
            type_known = 1'b1;
        end
        else
        begin
            kind       = KIND_ACCEL;
            type_known = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;
        data_we    = 1'b0;
        frame_done = 1'b0;
        pos_eff    = ((pos_reg < POS_FIRST_DATA) || (pos_reg > POS_CHECKSUM)) ?
                     POS_FIRST_DATA : pos_reg;
        pos_off    = pos_eff - POS_FIRST_DATA;
        data_idx   = pos_off[2:0];

        if (accept)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    type_next  = byte_in;
                    sum_next   = sum_reg + byte_in;
                    pos_next   = POS_FIRST_DATA;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (pos_eff != POS_CHECKSUM)
                    begin
                        data_we  = 1'b1;
                        sum_next = sum_reg + byte_in;
                        pos_next = pos_eff + 4'd1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = 4'd0;
                        sum_next   = 8'd0;
                        frame_done = (byte_in == sum_reg) && type_known;
                    end
                end
                default:
                begin
                    if (byte_in == FRAME_HEADER)
                    begin
                        sum_next   = byte_in;
                        pos_next   = 4'd1;
                        phase_next = PH_TYPE;
                    end
                end
            endcase
        end

        frame_valid_next = frame_valid_reg;
        if (frame_take)
        begin
            frame_valid_next = 1'b0;
        end
        if (frame_done)
        begin
            frame_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_code_reg  <= ACCEL_TYPE_RESET;
            gyro_code_reg   <= GYRO_TYPE_RESET;
            angle_code_reg  <= ANGLE_TYPE_RESET;
            phase_reg       <= PH_HUNT;
            pos_reg         <= 4'd0;
            sum_reg         <= 8'd0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACCEL_TYPE: accel_code_reg <= cfg_data;
                    CFG_GYRO_TYPE:  gyro_code_reg  <= cfg_data;
                    CFG_ANGLE_TYPE: angle_code_reg <= cfg_data;
                    default:        ;
                endcase
            end
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        if (data_we)
        begin
            data_reg[data_idx] <= byte_in;
        end
        if (frame_done)
        begin
            frame_reg.kind  <= kind;
            frame_reg.raw_x <= {data_reg[1], data_reg[0]};
            frame_reg.raw_y <= {data_reg[3], data_reg[2]};
            frame_reg.raw_z <= {data_reg[5], data_reg[4]};
            frame_reg.raw_t <= {data_reg[7], data_reg[6]};
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

`default_nettype wire

// File: design/isp_scaler.sv
// Fixed-point scaling of a checked frame and the result register.
`default_nettype none

module isp_scaler
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 frame_valid,
    input  wire isp_pkg::frame_t      frame,
    output logic                      frame_take,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                packet_kind,
    output logic signed [19:0]        value_x,
    output logic signed [19:0]        value_y,
    output logic signed [19:0]        value_z,
    output logic signed [17:0]        temperature
);
    import isp_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          kind_reg;
    logic signed [19:0]  x_reg, y_reg, z_reg;
    logic signed [17:0]  temp_reg;

    logic signed [17:0]  coef;
    logic signed [33:0]  prod_x, prod_y, prod_z;
    logic signed [34:0]  prod_t;
    logic signed [33:0]  shf_x, shf_y, shf_z;
    logic signed [34:0]  shf_t;

    assign frame_take = frame_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (frame.kind)
            KIND_ACCEL: coef = ACCEL_COEF;
            KIND_GYRO:  coef = GYRO_COEF;
            default:    coef = ANGLE_COEF;
        endcase
    end

    assign prod_x = frame.raw_x * coef;
    assign prod_y = frame.raw_y * coef;
    assign prod_z = frame.raw_z * coef;
    assign prod_t = frame.raw_t * TEMP_COEF;
    assign shf_t  = prod_t >>> TEMP_SHIFT;

    // Arithmetic shifts give rounding toward minus infinity.
    always_comb
    begin
        case (frame.kind)
            KIND_ACCEL:
            begin
                shf_x = prod_x >>> ACCEL_SHIFT;
                shf_y = prod_y >>> ACCEL_SHIFT;
                shf_z = prod_z >>> ACCEL_SHIFT;
            end
            KIND_GYRO:
            begin
                shf_x = prod_x >>> GYRO_SHIFT;
                shf_y = prod_y >>> GYRO_SHIFT;
                shf_z = prod_z >>> GYRO_SHIFT;
            end
            default:
            begin
                shf_x = prod_x >>> ANGLE_SHIFT;
                shf_y = prod_y >>> ANGLE_SHIFT;
                shf_z = prod_z >>> ANGLE_SHIFT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (frame_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            kind_reg <= frame.kind;
            x_reg    <= shf_x[19:0];
            y_reg    <= shf_y[19:0];
            z_reg    <= shf_z[19:0];
            temp_reg <= (frame.kind == KIND_ACCEL) ? shf_t[17:0] : 18'sd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packet_kind = kind_reg;
    assign value_x     = x_reg;
    assign value_y     = y_reg;
    assign value_z     = z_reg;
    assign temperature = temp_reg;

endmodule

`default_nettype wire

// File: design/imu_serial_packet_parser.sv
// Top level of the IMU serial packet parser: framer followed by scaler.
// Throughput: one byte transaction per clock cycle while in_stall is low.
// Path of a result: the checksum byte that completes a good frame loads the frame register,
// and the scaler's result register then takes the frame once it has room for it.
// Reset (rst_n, asynchronous, active low) returns the parser to header hunting, clears
// the running checksum and all valid flags, and loads the type codes 81, 82 and 83.
`default_nettype none

module imu_serial_packet_parser
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    // Byte input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           byte_in,
    // Result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                packet_kind,
    output logic signed [19:0]        value_x,
    output logic signed [19:0]        value_y,
    output logic signed [19:0]        value_z,
    output logic signed [17:0]        temperature
);
    import isp_pkg::*;

    // The framer keeps the parse state, the running checksum and the stored
    // data bytes, so each byte is handled in the cycle it is accepted. A frame
    // whose checksum is good and whose type byte matches one of the three type
    // codes is captured in the framer's frame register. Frames with a bad
    // checksum or an unknown type never leave the framer.
    logic   frame_valid;
    logic   frame_take;
    frame_t frame;

    isp_framer u_framer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take)
    );

    // The scaler multiplies each raw axis by the constant of its frame kind,
    // floors with an arithmetic shift and holds the result in the output
    // register. The input only stalls when a frame is waiting and the result
    // register cannot take it, so bytes keep flowing while a result waits.
    isp_scaler u_scaler
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packet_kind (packet_kind),
        .value_x     (value_x),
        .value_y     (value_y),
        .value_z     (value_z),
        .temperature (temperature)
    );

endmodule

`default_nettype wire
